### hw/rtl/retentive_delay_and_pulse_timer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the retentive delay and pulse timer
// ---------------------------------------------------------------------------
`ifndef RETENTIVE_DELAY_AND_PULSE_TIMER_DEFINES_SVH
`define RETENTIVE_DELAY_AND_PULSE_TIMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RDPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdpt assertion failed");

// next-cycle implication, checked out of reset
`define RDPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdpt assertion failed");

`endif

### hw/rtl/rdpt_pkg.sv
// ---------------------------------------------------------------------------
// rdpt_pkg
// Shared types and constants of the retentive delay and pulse timer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdpt_pkg;

   localparam int TIME_W           = 16;
   localparam int FRAC_BITS_DEFAULT = 10;

   typedef enum logic [0:0] {
      MODE_ON_DELAY = 1'b0,
      MODE_PULSE    = 1'b1
   } mode_type;

   typedef struct packed {
      logic out_level;
      logic pulse_active;
      logic last_run;
   } flags_type;

endpackage

`default_nettype wire

### hw/rtl/rdpt_ifs.sv
// ---------------------------------------------------------------------------
// rdpt channel interfaces
// Valid/ready channels for tick beats, result beats and the mode register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rdpt_req_if
   import rdpt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] tick_time;
   logic              run_in;
   logic              clear_in;
   logic [TIME_W-1:0] setpoint;

   modport source (output valid, tick_time, run_in, clear_in, setpoint, input ready);
   modport sink   (input valid, tick_time, run_in, clear_in, setpoint, output ready);
endinterface

interface rdpt_rsp_if
   import rdpt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              timer_out;
   logic [TIME_W-1:0] seconds_done;
   logic [TIME_W-1:0] seconds_left;

   modport source (output valid, timer_out, seconds_done, seconds_left, input ready);
   modport sink   (input valid, timer_out, seconds_done, seconds_left, output ready);
endinterface

interface rdpt_csr_if;
   logic valid;
   logic ready;
   logic timer_mode;

   modport source (output valid, timer_mode, input ready);
   modport sink   (input valid, timer_mode, output ready);
endinterface

`default_nettype wire

### hw/rtl/rdpt_next.sv
// ---------------------------------------------------------------------------
// rdpt_next
// Next-state logic for one tick: saturating accumulate, cap and clamp,
// on-delay and pulse behavior.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdpt_next
   import rdpt_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire mode_type                     mode,
   input  wire logic [TIME_W+FRAC_BITS-1:0]  elapsed,
   input  wire flags_type                    flags,
   input  wire logic [TIME_W-1:0]            done,
   input  wire logic [TIME_W-1:0]            left,
   input  wire logic [TIME_W-1:0]            tick_time,
   input  wire logic                         run_in,
   input  wire logic                         clear_in,
   input  wire logic [TIME_W-1:0]            setpoint,
   output      logic [TIME_W+FRAC_BITS-1:0]  elapsed_in,
   output      flags_type                    flags_in,
   output      logic [TIME_W-1:0]            done_in,
   output      logic [TIME_W-1:0]            left_in
);

   localparam int EW = TIME_W + FRAC_BITS;

   logic [EW:0]          sum;
   logic [EW-1:0]        sat;
   logic [TIME_W-1:0]    whole;
   logic [EW-1:0]        sp_fix;
   logic [TIME_W-1:0]    done_raw;
   logic [TIME_W-1:0]    done_cap;
   logic                 pulse_on;

   always_comb begin
      sum      = (EW+1)'(elapsed) + (EW+1)'(tick_time);
      sat      = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];
      whole    = sat[EW-1:FRAC_BITS];
      sp_fix   = EW'(setpoint) << FRAC_BITS;
      done_raw = flags.out_level ? done : whole;
      done_cap = (done_raw >= setpoint) ? setpoint : done_raw;
      pulse_on = flags.pulse_active | (~flags.last_run & run_in);

      elapsed_in        = elapsed;
      flags_in          = flags;
      flags_in.last_run = run_in;
      done_in           = done;
      left_in           = left;

      priority if (clear_in) begin
         elapsed_in         = '0;
         flags_in.out_level = 1'b0;
         done_in            = '0;
         left_in            = setpoint;
      end else if (mode == MODE_ON_DELAY) begin
         if (run_in) begin
            if (!flags.out_level) begin
               elapsed_in = sat;
            end
            done_in = done_cap;
            left_in = setpoint - done_cap;
            if (done_cap == setpoint) begin
               flags_in.out_level = 1'b1;
            end
         end
      end else begin
         flags_in.pulse_active = pulse_on;
         if (pulse_on) begin
            flags_in.out_level = 1'b1;
            elapsed_in         = sat;
            if (sat >= sp_fix) begin
               flags_in.out_level    = 1'b0;
               flags_in.pulse_active = 1'b0;
               elapsed_in            = '0;
            end
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/retentive_delay_and_pulse_timer.sv
// ---------------------------------------------------------------------------
// retentive_delay_and_pulse_timer
// Each request beat is one timer tick; each yields one response beat with the
// output level, whole seconds done (capped at setpoint) and seconds left.
// Mode 0 is a retentive on-delay, mode 1 an edge-triggered pulse. Elapsed
// time is unsigned fixed point with FRAC_BITS fraction bits, saturating.
// One beat per cycle: the timer state and the response register update in
// the accepting cycle, and a new request is taken whenever the response
// register is empty or drained in the same cycle. The mode register is to
// be written with the timer idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "retentive_delay_and_pulse_timer_defines.svh"

module retentive_delay_and_pulse_timer
   import rdpt_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   rdpt_req_if.sink  req_chan,
   rdpt_rsp_if.source rsp_chan,
   rdpt_csr_if.sink  csr_chan
);

   localparam int EW = TIME_W + FRAC_BITS;

   mode_type          mode_ff;
   logic [EW-1:0]     elapsed_ff, elapsed_in;
   flags_type         flags_ff, flags_in;
   logic [TIME_W-1:0] done_ff, done_in;
   logic [TIME_W-1:0] left_ff, left_in;

   logic              rsp_valid_ff;
   logic              rsp_out_ff;
   logic [TIME_W-1:0] rsp_done_ff;
   logic [TIME_W-1:0] rsp_left_ff;

   logic              accept;

   assign req_chan.ready = ~reset & (~rsp_valid_ff | rsp_chan.ready);
   assign csr_chan.ready = ~reset;
   assign accept         = req_chan.valid & req_chan.ready;

   rdpt_next #(
      .FRAC_BITS (FRAC_BITS)
   ) u_next (
      .mode       (mode_ff),
      .elapsed    (elapsed_ff),
      .flags      (flags_ff),
      .done       (done_ff),
      .left       (left_ff),
      .tick_time  (req_chan.tick_time),
      .run_in     (req_chan.run_in),
      .clear_in   (req_chan.clear_in),
      .setpoint   (req_chan.setpoint),
      .elapsed_in (elapsed_in),
      .flags_in   (flags_in),
      .done_in    (done_in),
      .left_in    (left_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ON_DELAY;
         elapsed_ff   <= '0;
         flags_ff     <= '0;
         done_ff      <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            mode_ff <= mode_type'(csr_chan.timer_mode);
         end
         if (accept) begin
            elapsed_ff   <= elapsed_in;
            flags_ff     <= flags_in;
            done_ff      <= done_in;
            left_ff      <= left_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_out_ff  <= flags_in.out_level;
         rsp_done_ff <= done_in;
         rsp_left_ff <= left_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.timer_out    = rsp_out_ff;
   assign rsp_chan.seconds_done = rsp_done_ff;
   assign rsp_chan.seconds_left = rsp_left_ff;

   `RDPT_ASSERT_NOW(a_stall_blocks_req, clock, reset,
      rsp_valid_ff && !rsp_chan.ready, !req_chan.ready)
   `RDPT_ASSERT_NEXT(a_accept_gives_rsp, clock, reset,
      accept, rsp_valid_ff)
   `RDPT_ASSERT_NEXT(a_clear_zeroes, clock, reset,
      accept && req_chan.clear_in,
      !rsp_out_ff && rsp_done_ff == '0 && rsp_left_ff == $past(req_chan.setpoint))
   `RDPT_ASSERT_NEXT(a_on_delay_sum, clock, reset,
      accept && !req_chan.clear_in && req_chan.run_in && mode_ff == MODE_ON_DELAY,
      rsp_left_ff == $past(req_chan.setpoint) - rsp_done_ff)

endmodule

`default_nettype wire

### dv/rdpt_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdpt_checker
// Watches the tick, result and mode channels of the timer. Every tick beat
// runs through a cycle-free model of the timer state; each result beat is
// compared field by field with the oldest predicted reading.
// ---------------------------------------------------------------------------

module rdpt_checker
   import rdpt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rdpt_req_if       req_mon,
   rdpt_rsp_if       rsp_mon,
   rdpt_csr_if       csr_mon,
   output int        fail_count,
   output int        pending,
   output int        checked
);

   localparam int FRAC_W    = FRAC_BITS_DEFAULT;
   localparam int ELAPSED_W = TIME_W + FRAC_W;
   localparam logic [ELAPSED_W-1:0] ELAPSED_TOP = '1;

   typedef struct packed {
      logic              timer_out;
      logic [TIME_W-1:0] seconds_done;
      logic [TIME_W-1:0] seconds_left;
   } reading_type;

   mode_type             mode_q;
   logic [ELAPSED_W-1:0] elapsed_fx;
   logic                 out_lvl;
   logic                 pulse_on;
   logic                 run_prev;
   logic [TIME_W-1:0]    secs_done;
   logic [TIME_W-1:0]    secs_left;

   reading_type expected_readings[$];
   int          fails = 0;
   int          n_checked = 0;

   function automatic logic [ELAPSED_W-1:0] sat_add(logic [ELAPSED_W-1:0] acc,
                                                    logic [TIME_W-1:0] tick);
      logic [ELAPSED_W:0] sum;
      sum = {1'b0, acc} + (ELAPSED_W+1)'(tick);
      return sum[ELAPSED_W] ? ELAPSED_TOP : sum[ELAPSED_W-1:0];
   endfunction

   task automatic advance_timer(input logic [TIME_W-1:0] tick, input logic run,
                                input logic clr, input logic [TIME_W-1:0] sp,
                                output reading_type rd);
      logic rose;
      rose     = run && !run_prev;
      run_prev = run;
      if (clr) begin
         secs_done  = '0;
         secs_left  = sp;
         elapsed_fx = '0;
         out_lvl    = 1'b0;
      end else if (mode_q == MODE_ON_DELAY) begin
         if (run) begin
            if (!out_lvl) begin
               elapsed_fx = sat_add(elapsed_fx, tick);
               secs_done  = elapsed_fx[ELAPSED_W-1:FRAC_W];
            end
            if (secs_done >= sp) secs_done = sp;
            secs_left = sp - secs_done;
            if (secs_left == '0) out_lvl = 1'b1;
         end
      end else begin
         if (rose) pulse_on = 1'b1;
         if (pulse_on) begin
            out_lvl    = 1'b1;
            elapsed_fx = sat_add(elapsed_fx, tick);
            if (elapsed_fx >= {sp, {FRAC_W{1'b0}}}) begin
               out_lvl    = 1'b0;
               elapsed_fx = '0;
               pulse_on   = 1'b0;
            end
         end
      end
      rd = '{out_lvl, secs_done, secs_left};
   endtask

   function automatic int field_diff(string name, logic [TIME_W-1:0] want,
                                     logic [TIME_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : monitor
      reading_type want;
      if (reset) begin
         mode_q     = MODE_ON_DELAY;
         elapsed_fx = '0;
         out_lvl    = 1'b0;
         pulse_on   = 1'b0;
         run_prev   = 1'b0;
         secs_done  = '0;
         secs_left  = '0;
         expected_readings.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) mode_q = mode_type'(csr_mon.timer_mode);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_readings.size() == 0) begin
               $error("result beat with no tick outstanding");
               fails++;
            end else begin
               want = expected_readings.pop_front();
               fails += field_diff("timer_out", TIME_W'(want.timer_out),
                                   TIME_W'(rsp_mon.timer_out));
               fails += field_diff("seconds_done", want.seconds_done, rsp_mon.seconds_done);
               fails += field_diff("seconds_left", want.seconds_left, rsp_mon.seconds_left);
               n_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_timer(req_mon.tick_time, req_mon.run_in, req_mon.clear_in,
                          req_mon.setpoint, want);
            expected_readings.push_back(want);
         end
      end
      fail_count <= fails;
      pending    <= expected_readings.size();
      checked    <= n_checked;
   end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the retentive delay and pulse timer. Directed
// ticks hit on-delay capping, pulse start/end and clear cases, then random
// tick sequences run in both modes under random idling, a long result
// hold-off and a full drain.
// ---------------------------------------------------------------------------

module tb_top;
   import rdpt_pkg::*;

   localparam int RESET_CYCLES   = 5;
   localparam int DRAIN_CYCLES   = 8;
   localparam int QUIET_LIMIT    = 4000;
   localparam int HOLD_CYCLES    = 120;
   localparam int RANDOM_ITEMS   = 500;
   localparam logic [TIME_W-1:0] T_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rdpt_req_if req_chan ();
   rdpt_rsp_if rsp_chan ();
   rdpt_csr_if csr_chan ();

   retentive_delay_and_pulse_timer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   int fail_count;
   int pending;
   int checked;

   rdpt_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   bit       tx_idle_on = 1'b1;
   bit       rx_idle_on = 1'b1;
   bit       hold_go    = 1'b0;
   int       items_sent = 0;
   int       mode_writes = 0;
   int       quiet_cycles = 0;
   mode_type cur_mode = MODE_ON_DELAY;

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_go) begin
            for (int i = 0; i < HOLD_CYCLES; i++) begin
               rsp_chan.ready <= 1'b0;
               @(posedge clock);
            end
            hold_go = 1'b0;
         end else begin
            rsp_chan.ready <= !(rx_idle_on && $urandom_range(99) < 30);
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_tick(input logic [TIME_W-1:0] tick, input logic run,
                            input logic clr, input logic [TIME_W-1:0] sp);
      while (tx_idle_on && $urandom_range(99) < 30) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.tick_time <= tick;
      req_chan.run_in    <= run;
      req_chan.clear_in  <= clr;
      req_chan.setpoint  <= sp;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   // caller has already lowered the tick valid in this step
   task automatic await_drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      req_chan.valid <= 1'b0;
      await_drain();
      csr_chan.valid      <= 1'b1;
      csr_chan.timer_mode <= m;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      cur_mode = m;
      mode_writes++;
   endtask

   function automatic logic [TIME_W-1:0] rand_tick();
      case ($urandom_range(3))
         0: return TIME_W'($urandom);
         1: return TIME_W'($urandom_range(0, 2047));
         2: return TIME_W'($urandom_range(512, 4096));
         default: return $urandom_range(1) ? T_MAX : '0;
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] rand_sp();
      case ($urandom_range(7))
         0: return TIME_W'($urandom);
         1: return '0;
         2: return T_MAX;
         default: return TIME_W'($urandom_range(1, 8));
      endcase
   endfunction

   initial begin : stimulus
      int                n;
      int                base;
      int                len;
      int                kind;
      bit                held;
      bit                paused;
      logic              run_lvl;
      logic [TIME_W-1:0] sp;

      req_chan.valid      <= 1'b0;
      req_chan.tick_time  <= '0;
      req_chan.run_in     <= 1'b0;
      req_chan.clear_in   <= 1'b0;
      req_chan.setpoint   <= '0;
      csr_chan.valid      <= 1'b0;
      csr_chan.timer_mode <= MODE_ON_DELAY;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // on-delay: accumulate, hold with run low, cap, zero setpoint
      write_mode(MODE_ON_DELAY);
      send_tick(16'd0,    1'b0, 1'b1, 16'd3);
      send_tick(16'd1024, 1'b1, 1'b0, 16'd3);
      send_tick(T_MAX,    1'b0, 1'b0, 16'd3);
      send_tick(16'd1023, 1'b1, 1'b0, 16'd3);
      send_tick(16'd1025, 1'b1, 1'b0, 16'd3);
      send_tick(T_MAX,    1'b1, 1'b0, 16'd2);
      send_tick(16'd5,    1'b1, 1'b0, 16'd0);
      send_tick(16'd0,    1'b0, 1'b1, T_MAX);
      send_tick(16'd0,    1'b1, 1'b0, T_MAX);
      send_tick(T_MAX,    1'b1, 1'b0, 16'd0);
      send_tick(16'd0,    1'b0, 1'b1, 16'd0);

      // pulse: normal pulse, zero setpoint, instant end, clear mid-pulse
      write_mode(MODE_PULSE);
      send_tick(16'd0,    1'b0, 1'b0, 16'd2);
      send_tick(16'd1024, 1'b1, 1'b0, 16'd2);
      send_tick(16'd1023, 1'b1, 1'b0, 16'd2);
      send_tick(16'd1,    1'b0, 1'b0, 16'd2);
      send_tick(16'd0,    1'b1, 1'b0, 16'd0);
      send_tick(16'd0,    1'b0, 1'b0, 16'd5);
      send_tick(T_MAX,    1'b1, 1'b0, 16'd5);
      send_tick(16'd0,    1'b0, 1'b0, 16'd10);
      send_tick(16'd2048, 1'b1, 1'b0, 16'd10);
      send_tick(16'd100,  1'b1, 1'b1, 16'd10);
      send_tick(16'd1024, 1'b1, 1'b0, 16'd10);
      send_tick(T_MAX,    1'b1, 1'b0, 16'd10);
      send_tick(T_MAX,    1'b1, 1'b1, T_MAX);

      base   = items_sent;
      n      = 0;
      held   = 1'b0;
      paused = 1'b0;
      while (n < RANDOM_ITEMS) begin
         tx_idle_on = !(n >= 220 && n < 320);
         rx_idle_on = tx_idle_on;
         if (!held && n >= 150) begin
            hold_go = 1'b1;
            held    = 1'b1;
         end
         if (!paused && n >= 350) begin
            req_chan.valid <= 1'b0;
            await_drain();
            repeat ($urandom_range(5, 20)) @(posedge clock);
            paused = 1'b1;
         end
         kind = $urandom_range(9);
         if (kind >= 1 && kind <= 4 && (cur_mode != MODE_ON_DELAY || $urandom_range(5) == 0))
            write_mode(MODE_ON_DELAY);
         else if (kind >= 5 && (cur_mode != MODE_PULSE || $urandom_range(5) == 0))
            write_mode(MODE_PULSE);
         len = $urandom_range(4, 16);
         sp  = rand_sp();
         if (kind == 0) begin
            repeat (5)
               send_tick(TIME_W'($urandom), 1'($urandom), 1'($urandom_range(3) == 0),
                         TIME_W'($urandom));
         end else if (kind <= 4) begin
            send_tick(rand_tick(), 1'($urandom), 1'b1, sp);
            repeat (len) begin
               if ($urandom_range(7) == 0) sp = rand_sp();
               send_tick(rand_tick(), $urandom_range(9) < 8, $urandom_range(19) == 0, sp);
            end
         end else begin
            run_lvl = 1'b0;
            send_tick(rand_tick(), run_lvl, 1'b0, sp);
            repeat (len) begin
               if ($urandom_range(9) < 4) run_lvl = !run_lvl;
               if ($urandom_range(9) == 0) sp = rand_sp();
               send_tick(rand_tick(), run_lvl, $urandom_range(19) == 0, sp);
            end
         end
         n = items_sent - base;
      end

      req_chan.valid <= 1'b0;
      await_drain();

      $display("Sent %0d tick beats (%0d random) over %0d mode writes; %0d results checked.",
               items_sent, n, mode_writes, checked);
      $display("Covered on-delay hold/cap, pulse edges, clears and back-pressure.");
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rdpt_pkg.sv
hw/rtl/rdpt_ifs.sv
hw/rtl/rdpt_next.sv
hw/rtl/retentive_delay_and_pulse_timer.sv
dv/rdpt_checker.sv
dv/tb_top.sv
